/* rtl/tfbm_pkg.sv */
// Shared constants and types for the tileable fBm value-noise sampler.
package tfbm_pkg;

  // Octave setup
  localparam int OCTAVE_COUNT = 4;
  localparam int OCT_IDX_W    = (OCTAVE_COUNT > 1) ? $clog2(OCTAVE_COUNT) : 1;

  // Tile of 256 texels: the lattice fraction in Q0.8 is the low byte of coord * f.
  localparam int TILE_LOG2 = 8;

  // Input field widths
  localparam int COORD_W = 8;
  localparam int LG_IN_W = 3;
  localparam int SEED_W  = 32;

  // Lattice frequency exponent and cell index widths
  localparam int LG_MAX = (1 << LG_IN_W) - 1 + OCTAVE_COUNT - 1;
  localparam int LG_W   = $clog2(LG_MAX + 1);
  localparam int CELL_W = COORD_W + LG_MAX - TILE_LOG2;
  localparam int P_W    = COORD_W + LG_MAX;
  localparam int FRAC_W = 8;

  // Hash and seed constants
  localparam logic [SEED_W-1:0] HASH_MUL  = 32'h045d_9f3b;
  localparam int                ROW_SHIFT = 16;
  localparam logic [SEED_W-1:0] SEED_STEP = 32'd1000;

  // Value path
  localparam int VAL_W = 16;
  localparam int S_W   = VAL_W + 1;
  localparam int ACC_W = VAL_W + OCTAVE_COUNT;

  // Normalization: acc / ((2^N - 1) * 257) by reciprocal multiply plus one correction
  localparam int unsigned TOTAL       = ((1 << OCTAVE_COUNT) - 1) * 257;
  localparam int          RECIP_SHIFT = 32;
  localparam logic [31:0] RECIP       = 32'((64'd1 << RECIP_SHIFT) / TOTAL);
  localparam int          PROD_W      = ACC_W + 32;
  localparam int          Q_W         = 9;
  localparam int          REM_W       = $clog2(2 * TOTAL);

  // Pipeline depth
  localparam int OCT_STAGES  = 7;
  localparam int PIPE_STAGES = OCT_STAGES + 4;

  typedef logic [OCT_STAGES-1:0] oct_adv_t;

endpackage

/* rtl/tfbm_octave.sv */
// One octave of lattice value noise: corners, hash, smoothstep and bilinear blend.
module tfbm_octave (
  input  logic                               clk_i,
  input  tfbm_pkg::oct_adv_t                 adv_i,
  input  logic [tfbm_pkg::OCT_IDX_W-1:0]     oct_idx_i,
  input  logic [tfbm_pkg::COORD_W-1:0]       pixel_x_i,
  input  logic [tfbm_pkg::COORD_W-1:0]       pixel_y_i,
  input  logic [tfbm_pkg::LG_IN_W-1:0]       base_freq_log2_i,
  input  logic [tfbm_pkg::SEED_W-1:0]        seed_i,
  output logic [tfbm_pkg::VAL_W-1:0]         value_o
);
  import tfbm_pkg::*;

  localparam logic [S_W-1:0] S_ONE  = S_W'(1) << VAL_W;
  localparam logic [9:0]     SM_K   = 10'd768;
  localparam int             SM_PW  = 2 * FRAC_W + 10;
  localparam int             LERP_W = 2 * VAL_W + 1;

  function automatic logic [VAL_W-1:0] lerp16(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b,
                                              input logic [S_W-1:0]   s);
    logic [S_W-1:0]    sc;
    logic [LERP_W-1:0] sum;
    sc  = S_ONE - s;
    sum = LERP_W'(a) * LERP_W'(sc) + LERP_W'(b) * LERP_W'(s);
    return sum[2*VAL_W-1:VAL_W];
  endfunction

  // Stage 0: lattice corners and fractions
  logic [LG_W-1:0]   lg;
  logic [P_W-1:0]    px_p, py_p;
  logic [CELL_W-1:0] cmask, cell_x, cell_y;
  logic [CELL_W-1:0] cx_q [2];
  logic [CELL_W-1:0] cy_q [2];
  logic [FRAC_W-1:0] tx_q, ty_q;
  logic [SEED_W-1:0] oseed_q;

  always_comb begin
    lg     = LG_W'(base_freq_log2_i) + LG_W'(oct_idx_i);
    px_p   = P_W'(pixel_x_i) << lg;
    py_p   = P_W'(pixel_y_i) << lg;
    cell_x = px_p[P_W-1:TILE_LOG2];
    cell_y = py_p[P_W-1:TILE_LOG2];
    cmask  = ~({CELL_W{1'b1}} << lg);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      cx_q[0] <= cell_x;
      cx_q[1] <= (cell_x + CELL_W'(1)) & cmask;
      cy_q[0] <= cell_y;
      cy_q[1] <= (cell_y + CELL_W'(1)) & cmask;
      tx_q    <= px_p[TILE_LOG2-1:0];
      ty_q    <= py_p[TILE_LOG2-1:0];
      oseed_q <= seed_i + SEED_W'(oct_idx_i) * SEED_STEP;
    end
  end

  // Stage 1: hash keys (corner j: x from bit 0, y from bit 1), smoothstep terms
  logic [SEED_W-1:0]   key_q [4];
  logic [2*FRAC_W-1:0] ttx_q, tty_q;
  logic [9:0]          wtx_q, wty_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      for (int j = 0; j < 4; j++) begin
        key_q[j] <= SEED_W'(cx_q[j % 2]) + (SEED_W'(cy_q[j / 2]) << ROW_SHIFT)
                  + SEED_W'(cy_q[j / 2]) + oseed_q;
      end
      ttx_q <= (2*FRAC_W)'(tx_q) * (2*FRAC_W)'(tx_q);
      tty_q <= (2*FRAC_W)'(ty_q) * (2*FRAC_W)'(ty_q);
      wtx_q <= SM_K - {1'b0, tx_q, 1'b0};
      wty_q <= SM_K - {1'b0, ty_q, 1'b0};
    end
  end

  // Stage 2: first hash round, smoothstep product
  logic [SEED_W-1:0] h1_q [4];
  logic [SM_PW-1:0]  smx, smy;
  logic [S_W-1:0]    sx2_q, sy2_q;

  always_comb begin
    smx = SM_PW'(ttx_q) * SM_PW'(wtx_q);
    smy = SM_PW'(tty_q) * SM_PW'(wty_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      for (int j = 0; j < 4; j++) begin
        h1_q[j] <= (key_q[j] ^ (key_q[j] >> 16)) * HASH_MUL;
      end
      sx2_q <= smx[S_W+7:8];
      sy2_q <= smy[S_W+7:8];
    end
  end

  // Stage 3: second hash round
  logic [SEED_W-1:0] h2_q [4];
  logic [S_W-1:0]    sx3_q, sy3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      for (int j = 0; j < 4; j++) begin
        h2_q[j] <= (h1_q[j] ^ (h1_q[j] >> 16)) * HASH_MUL;
      end
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
    end
  end

  // Stage 4: final xorshift, keep low 16 bits
  logic [VAL_W-1:0] cv_q [4];
  logic [S_W-1:0]   sx4_q, sy4_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      for (int j = 0; j < 4; j++) begin
        cv_q[j] <= h2_q[j][15:0] ^ h2_q[j][31:16];
      end
      sx4_q <= sx3_q;
      sy4_q <= sy3_q;
    end
  end

  // Stage 5: blend along x on both rows
  logic [VAL_W-1:0] r0_q, r1_q;
  logic [S_W-1:0]   sy5_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[5]) begin
      r0_q  <= lerp16(cv_q[0], cv_q[1], sx4_q);
      r1_q  <= lerp16(cv_q[2], cv_q[3], sx4_q);
      sy5_q <= sy4_q;
    end
  end

  // Stage 6: blend along y
  logic [VAL_W-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[6]) begin
      value_q <= lerp16(r0_q, r1_q, sy5_q);
    end
  end

  assign value_o = value_q;

endmodule

/* rtl/tileable_fbm_value_noise.sv */
// Top level of the tileable four-octave fBm value-noise sampler.
//
// Usage
//   Input channel: pixel_x_i, pixel_y_i, base_freq_log2_i and seed_i travel as one beat,
//   qualified by in_valid_i and held off by in_stall_o. Output channel: one noise_byte_o
//   per input beat, qualified by out_valid_o and held off by out_stall_i.
//   An accepted input beat passes the stage registers 0..10 in order to its output beat.
//   Throughput is one beat per cycle while the output side does not stall: all octaves
//   run side by side and every stage holds its own valid bit.
//   Stage map: 0..6 per-octave lattice, hash (two 32x32 multiplies), smoothstep and blend;
//   7 octave weighting, 8 reciprocal multiply, 9 remainder, 10 correction/clamp/output.
//   The pipeline depth, not any shared unit, sets the latency.
//   Reset clears all stage valid bits; payload registers are not reset.
//   When the receiver stalls, the output beat holds steady. Stages behind it keep
//   filling until the first bubble is squeezed out; in_stall_o rises only when every
//   stage holds a beat, so nothing is dropped or repeated.
module tileable_fbm_value_noise (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tfbm_pkg::COORD_W-1:0]       pixel_x_i,
  input  logic [tfbm_pkg::COORD_W-1:0]       pixel_y_i,
  input  logic [tfbm_pkg::LG_IN_W-1:0]       base_freq_log2_i,
  input  logic [tfbm_pkg::SEED_W-1:0]        seed_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         noise_byte_o
);
  import tfbm_pkg::*;

  localparam int ST_ACC  = OCT_STAGES;
  localparam int ST_PROD = OCT_STAGES + 1;
  localparam int ST_REM  = OCT_STAGES + 2;
  localparam int ST_OUT  = OCT_STAGES + 3;

  // Valid bits and per-stage load enables; a stage loads when empty or when
  // the stage ahead of it loads.
  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES-1:0] rdy;

  always_comb begin
    rdy[PIPE_STAGES-1] = !v_q[PIPE_STAGES-1] || !out_stall_i;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  // Octave lanes, stages 0..6
  oct_adv_t         oct_adv;
  logic [VAL_W-1:0] oct_val [OCTAVE_COUNT];

  assign oct_adv = rdy[OCT_STAGES-1:0];

  for (genvar k = 0; k < OCTAVE_COUNT; k++) begin : g_oct
    tfbm_octave u_oct (
      .clk_i            (clk_i),
      .adv_i            (oct_adv),
      .oct_idx_i        (OCT_IDX_W'(k)),
      .pixel_x_i        (pixel_x_i),
      .pixel_y_i        (pixel_y_i),
      .base_freq_log2_i (base_freq_log2_i),
      .seed_i           (seed_i),
      .value_o          (oct_val[k])
    );
  end

  // Stage 7: weighted octave sum, weight halves per octave
  logic [ACC_W-1:0] acc_d, acc_q;

  always_comb begin
    acc_d = '0;
    for (int k = 0; k < OCTAVE_COUNT; k++) begin
      acc_d = acc_d + (ACC_W'(oct_val[k]) << (OCTAVE_COUNT - 1 - k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_ACC]) begin
      acc_q <= acc_d;
    end
  end

  // Stage 8: multiply by floor(2^32 / total); estimate is exact or one low
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc8_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_PROD]) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'(RECIP);
      acc8_q <= acc_q;
    end
  end

  // Stage 9: quotient estimate and its remainder
  logic [Q_W-1:0]   q_est, q_est_q;
  logic [ACC_W-1:0] q_back;
  logic [REM_W-1:0] rem_q;

  always_comb begin
    q_est  = prod_q[RECIP_SHIFT +: Q_W];
    q_back = ACC_W'(ACC_W'(q_est) * ACC_W'(TOTAL));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_REM]) begin
      q_est_q <= q_est;
      rem_q   <= REM_W'(acc8_q - q_back);
    end
  end

  // Stage 10: correct by one, clamp, output register
  logic [Q_W-1:0] q_fix;
  logic [7:0]     noise_q;

  assign q_fix = q_est_q + Q_W'(rem_q >= REM_W'(TOTAL));

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      noise_q <= (q_fix > Q_W'(255)) ? 8'hFF : q_fix[7:0];
    end
  end

  assign out_valid_o  = v_q[ST_OUT];
  assign noise_byte_o = noise_q;

  // Input only stalls when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // A beat in the first stage that cannot move stays put.
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !rdy[1]) |=> v_q[0])
    else $error("first stage beat lost while blocked");

  // Reciprocal estimate is at most one low.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_OUT - 1] |-> (REM_W'(rem_q) < REM_W'(2 * TOTAL)))
    else $error("normalization remainder out of range");

  // Normalized value never needs the clamp.
  a_q_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_OUT - 1] |-> (q_fix <= Q_W'(255)))
    else $error("normalized quotient above full scale");

endmodule

/* bench/fbm_noise_checker.sv */
// Watches both channels of the fBm noise sampler, predicts each sample and compares.
`timescale 1ns / 100ps

module fbm_noise_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [tfbm_pkg::COORD_W-1:0]  pixel_x_i,
  input  logic [tfbm_pkg::COORD_W-1:0]  pixel_y_i,
  input  logic [tfbm_pkg::LG_IN_W-1:0]  base_freq_log2_i,
  input  logic [tfbm_pkg::SEED_W-1:0]   seed_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [7:0]                    noise_byte_i,
  output int                            mismatch_count_o,
  output int                            pending_o
);
  import tfbm_pkg::*;

  localparam logic [31:0] ROW_STEP = (32'd1 << ROW_SHIFT) + 32'd1;

  logic [7:0] noise_due[$];

  function automatic logic [31:0] scramble(logic [31:0] v);
    v ^= v >> 16;
    v = v * HASH_MUL;
    v ^= v >> 16;
    v = v * HASH_MUL;
    v ^= v >> 16;
    return v;
  endfunction

  function automatic longint unsigned lattice_value(logic [31:0] cx, logic [31:0] cy,
                                                    logic [31:0] oseed);
    logic [31:0] h;
    h = scramble(cx + cy * ROW_STEP + oseed);
    return longint'(h[15:0]);
  endfunction

  // Smoothstep of a Q0.8 fraction, result in Q0.16
  function automatic longint unsigned ease(longint unsigned t);
    return (t * t * (768 - 2 * t)) >> 8;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned s);
    return (a * (65536 - s) + b * s) >> 16;
  endfunction

  function automatic longint unsigned octave_value(logic [COORD_W-1:0] px,
                                                   logic [COORD_W-1:0] py,
                                                   int lg, logic [31:0] oseed);
    longint unsigned mask, ppx, ppy, x0, x1, y0, y1, sx, sy, row0, row1;
    mask = (64'd1 << lg) - 1;
    ppx  = longint'(px) << lg;
    ppy  = longint'(py) << lg;
    // tile is 256 texels: the cell is p >> 8 and the Q0.8 fraction its low byte
    x0   = (ppx >> 8) & mask;
    x1   = ((ppx >> 8) + 1) & mask;
    y0   = (ppy >> 8) & mask;
    y1   = ((ppy >> 8) + 1) & mask;
    sx   = ease(ppx & 255);
    sy   = ease(ppy & 255);
    row0 = blend(lattice_value(32'(x0), 32'(y0), oseed),
                 lattice_value(32'(x1), 32'(y0), oseed), sx);
    row1 = blend(lattice_value(32'(x0), 32'(y1), oseed),
                 lattice_value(32'(x1), 32'(y1), oseed), sx);
    return blend(row0, row1, sy);
  endfunction

  function automatic logic [7:0] fbm_sample(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                            logic [LG_IN_W-1:0] lg, logic [SEED_W-1:0] seed);
    longint unsigned acc, q;
    logic [31:0]     oseed;
    acc = 0;
    for (int k = 0; k < OCTAVE_COUNT; k++) begin
      oseed = seed + SEED_STEP * k;
      acc += octave_value(px, py, int'(lg) + k, oseed) << (OCTAVE_COUNT - 1 - k);
    end
    q = acc / TOTAL;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  int         mismatches;
  logic [7:0] want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_due.delete();
      mismatches <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        noise_due.push_back(fbm_sample(pixel_x_i, pixel_y_i, base_freq_log2_i, seed_i));
      if (out_valid_i && !out_stall_i) begin
        if (noise_due.size() == 0) begin
          $display("%0t: unexpected noise beat, expected none, got %0d",
                   $time, noise_byte_i);
          mismatches <= mismatches + 1;
        end else begin
          want = noise_due.pop_front();
          if (noise_byte_i !== want) begin
            $display("%0t: noise_byte mismatch, expected %0d, got %0d",
                     $time, want, noise_byte_i);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  assign mismatch_count_o = mismatches;
  assign pending_o        = noise_due.size();

endmodule

/* bench/tileable_fbm_value_noise_test.sv */
// Top of the fBm noise sampler bench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tileable_fbm_value_noise_test;
  import tfbm_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  // The limit must outlast the long receiver hold-off plus the pipe depth.
  localparam int HANG_LIMIT   = 3000;
  localparam int RANDOM_BEATS = 1200;
  localparam int HOLD_AT      = 400;   // receiver beat count that triggers the long hold-off
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 4 * PIPE_STAGES;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [COORD_W-1:0]  pixel_x = '0;
  logic [COORD_W-1:0]  pixel_y = '0;
  logic [LG_IN_W-1:0]  base_lg = '0;
  logic [SEED_W-1:0]   seed = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          noise_byte;

  int mismatch_count;
  int pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tileable_fbm_value_noise dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .pixel_x_i        (pixel_x),
    .pixel_y_i        (pixel_y),
    .base_freq_log2_i (base_lg),
    .seed_i           (seed),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .noise_byte_o     (noise_byte)
  );

  fbm_noise_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .pixel_x_i        (pixel_x),
    .pixel_y_i        (pixel_y),
    .base_freq_log2_i (base_lg),
    .seed_i           (seed),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .noise_byte_i     (noise_byte),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // ---------------------------------------------------------------------------
  // Hang watchdog: any accepted beat on either side resets the count.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
      $display("tileable_fbm_value_noise_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. A random gap, possibly none, ahead of each beat, with stretches
  // where it streams back to back so the pipe sees full-rate traffic.
  // ---------------------------------------------------------------------------
  bit send_streaming = 1'b0;

  task automatic offer_texel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                             logic [LG_IN_W-1:0] lg, logic [SEED_W-1:0] sd);
    int gap;
    gap = send_streaming ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= px;
    pixel_y  <= py;
    base_lg  <= lg;
    seed     <= sd;
    @(posedge clk);
    // beat goes through on the first edge where stall is low
    while (in_stall) @(posedge clk);
  endtask

  // Seeds: half fully random, a quarter small (0..15), a quarter hugging the
  // 2^32 wrap so the per-octave seed steps and the hash key overflow.
  function automatic logic [SEED_W-1:0] pick_seed();
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFFF - $urandom_range(0, 4 * 1000);
      1:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [COORD_W-1:0] rx, ry;
    logic [LG_IN_W-1:0] rlg;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every base frequency, lattice cell edges,
    // frequencies past the intended range and seeds that wrap.
    offer_texel(8'd0,   8'd0,   3'd0, 32'h0000_0000);
    offer_texel(8'd255, 8'd255, 3'd0, 32'hFFFF_FFFF);
    offer_texel(8'd255, 8'd0,   3'd5, 32'h0000_0000);
    offer_texel(8'd0,   8'd255, 3'd5, 32'hFFFF_FFFF);
    for (int lg = 0; lg < 8; lg++)
      offer_texel(8'd128, 8'd64, lg[LG_IN_W-1:0], 32'h1234_5678);
    // cells narrower than a texel
    offer_texel(8'd255, 8'd255, 3'd7, 32'hDEAD_BEEF);
    offer_texel(8'd1,   8'd1,   3'd6, 32'h0000_0001);
    // fraction extremes: just past a lattice line and just short of the next
    offer_texel(8'd1,   8'd254, 3'd0, 32'h8000_0000);
    offer_texel(8'd127, 8'd129, 3'd1, 32'h7FFF_FFFF);
    // seeds that wrap from the second octave on, then only on the last
    offer_texel(8'd200, 8'd17,  3'd2, 32'hFFFF_FFFF - 32'd500);
    offer_texel(8'd17,  8'd200, 3'd3, 32'hFFFF_FFFF - 32'd2500);
    offer_texel(8'hAA,  8'h55,  3'd4, 32'hAAAA_AAAA);
    offer_texel(8'h55,  8'hAA,  3'd2, 32'h5555_5555);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 64 == 0) send_streaming = ($urandom_range(0, 2) == 0);
      rx  = COORD_W'($urandom_range(0, 255));
      ry  = COORD_W'($urandom_range(0, 255));
      // mostly the intended 0..5, some of the oversized ones
      rlg = LG_IN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(6, 7)
                                                 : $urandom_range(0, 5));
      offer_texel(rx, ry, rlg, pick_seed());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    // let any stray extra beat show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tileable_fbm_value_noise_test: done, clean");
    else
      $display("tileable_fbm_value_noise_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side. A random stall, possibly none, ahead of each beat, with stall-free
  // stretches, and once a long hold-off so the pipe fills and backs up.
  // ---------------------------------------------------------------------------
  initial begin
    int  hold;
    int  taken;
    bit  recv_streaming;
    taken          = 0;
    recv_streaming = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = recv_streaming ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AT) hold = HOLD_LEN;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 50 == 0) recv_streaming = ($urandom_range(0, 2) == 0);
    end
  end

endmodule
